/* sv/mrec_pkg.sv */
// Shared types, codes and constants of the multi-rate sensor capture block.
// No dependencies; compiled first.
`default_nettype none

package mrec_pkg;

  localparam int OFF_BITS     = 12;
  localparam int CNT_BITS     = 8;
  localparam int VALUE_BITS   = 14;
  localparam int NUM_SRC      = 3;
  localparam int NUM_FLT      = 4;
  localparam int REG_IDX_BITS = 1;

  typedef logic [1:0]              opcode_t;
  typedef logic [2:0]              sel_t;
  typedef logic [1:0]              src_t;
  typedef logic [1:0]              flt_idx_t;
  typedef logic [OFF_BITS-1:0]     off_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;

  localparam opcode_t OP_SAMPLE = 2'd0;
  localparam opcode_t OP_READ   = 2'd1;
  localparam opcode_t OP_RESET  = 2'd2;

  localparam sel_t SEL_MAIN      = 3'd0;
  localparam sel_t SEL_AUX       = 3'd1;
  localparam sel_t SEL_VDD       = 3'd2;
  localparam sel_t SEL_FLT_FIRST = 3'd3;
  localparam sel_t SEL_FLT_LAST  = 3'd6;
  localparam sel_t SEL_INVALID   = 3'd7;

  localparam src_t SRC_MAIN = 2'd0;
  localparam src_t SRC_AUX  = 2'd1;
  localparam src_t SRC_VDD  = 2'd2;

  localparam reg_idx_t REG_MAIN_OFFSET = 1'd0;
  localparam reg_idx_t REG_AUX_OFFSET  = 1'd1;

  localparam off_t MAIN_OFFSET_RST = 12'd164;
  localparam off_t AUX_OFFSET_RST  = 12'd962;

  localparam value_t VALUE_MAX = 14'sd8191;
  localparam value_t VALUE_MIN = -14'sd8192;

  // control from the capture pipe to the filter bank
  typedef struct packed {
    logic     upd;  // main-pressure sample: step all integrators
    logic     ld;   // load one integrator from the latest main sample
    flt_idx_t idx;
  } flt_ctrl_t;

  function automatic int unsigned flt_shift(flt_idx_t i);
    int unsigned s;
    unique case (i)
      2'd0:    s = 2;
      2'd1:    s = 4;
      2'd2:    s = 6;
      default: s = 9;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/mrec_if.sv */
// Request and result channels of the sensor capture block (valid/ready).
// Depends on mrec_pkg.
`default_nettype none

interface mrec_in_if #(
  parameter int SAMPLE_BITS = 12
);
  import mrec_pkg::*;

  logic                   valid;
  logic                   ready;
  opcode_t                opcode;
  logic [SAMPLE_BITS-1:0] sample_value;
  sel_t                   select;

  modport source (output valid, opcode, sample_value, select, input ready);
  modport sink   (input valid, opcode, sample_value, select, output ready);
endinterface

interface mrec_out_if;
  import mrec_pkg::*;

  logic   valid;
  logic   ready;
  logic   value_valid;
  value_t value;
  src_t   next_source;
  logic   reference_select;
  logic   error;

  modport source (output valid, value_valid, value, next_source, reference_select, error,
                  input ready);
  modport sink   (input valid, value_valid, value, next_source, reference_select, error,
                  output ready);
endinterface

`default_nettype wire

/* sv/multi_rate_ema_sensor_capture_core.sv */
// A request is registered in stage 1, then its result in the output register.
// Throughput: one request per cycle while results are taken; the source memory is
// read on accept, written back as stage 1 fires, same-entry overlap forwarded.
// The output register lets a request enter while a result still waits.
// Reset (rst, synchronous) clears control and filters and reloads the offset
// defaults; source memory entries read as zero until written, one valid bit each.
`default_nettype none

module multi_rate_ema_sensor_capture_core #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  mrec_in_if.sink                     cmd,
  mrec_out_if.source                  res,
  input  wire logic                   cfg_we,
  input  wire mrec_pkg::reg_idx_t     cfg_index,
  input  wire mrec_pkg::off_t         cfg_data
);
  import mrec_pkg::*;

  localparam int SW = SAMPLE_BITS;
  localparam int RW = CNT_BITS + SW;
  localparam int CW = ((SW > OFF_BITS) ? SW : OFF_BITS) + 2;
  localparam logic signed [CW-1:0] SAT_HI = CW'(VALUE_MAX);
  localparam logic signed [CW-1:0] SAT_LO = CW'(VALUE_MIN);

  // configuration
  off_t main_offset;
  off_t aux_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_offset <= MAIN_OFFSET_RST;
      aux_offset  <= AUX_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAIN_OFFSET: main_offset <= cfg_data;
        REG_AUX_OFFSET:  aux_offset  <= cfg_data;
        default:         ;
      endcase
    end
  end

  // handshake
  logic s1_valid;
  logic s1_fire;
  logic accept;

  assign s1_fire   = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !s1_valid || s1_fire;
  assign accept    = cmd.valid && cmd.ready;

  // round-robin source
  src_t cur_src;
  src_t cur_src_next;

  always_comb begin
    cur_src_next = cur_src;
    if (cmd.opcode == OP_SAMPLE) begin
      cur_src_next = (cur_src == SRC_VDD) ? SRC_MAIN : src_t'(cur_src + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_src <= SRC_MAIN;
    end else if (accept) begin
      cur_src <= cur_src_next;
    end
  end

  // source memory read address
  src_t rd_addr;

  always_comb begin
    priority if (cmd.opcode == OP_SAMPLE) begin
      rd_addr = cur_src;
    end else if (cmd.opcode == OP_READ && cmd.select <= SEL_VDD) begin
      rd_addr = src_t'(cmd.select);
    end else begin
      rd_addr = SRC_MAIN;
    end
  end

  // stage 1 request
  opcode_t       s1_op;
  logic [SW-1:0] s1_x;
  sel_t          s1_sel;
  src_t          s1_src;
  src_t          s1_src_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op        <= cmd.opcode;
      s1_x         <= cmd.sample_value;
      s1_sel       <= cmd.select;
      s1_src       <= rd_addr;
      s1_src_after <= cur_src_next;
    end
  end

  // source memory: {sample count, raw sample} per source
  logic [RW-1:0]      src_mem [NUM_SRC];
  logic [RW-1:0]      rd_q;
  logic [NUM_SRC-1:0] ent_valid;
  logic               rd_ent_valid;
  logic               wr_en;
  logic [RW-1:0]      wr_row;
  logic               fwd;
  logic [RW-1:0]      fwd_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      src_mem[s1_src] <= wr_row;
    end
    if (accept) begin
      rd_q <= src_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid    <= '0;
      rd_ent_valid <= 1'b0;
      fwd          <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_valid[s1_src] <= 1'b1;
      end
      if (accept) begin
        rd_ent_valid <= ent_valid[rd_addr];
        // write-back to the entry just read lands too late for the read
        fwd          <= wr_en && (s1_src == rd_addr);
      end else if (s1_fire) begin
        fwd <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_row <= wr_row;
    end
  end

  // stage 1 datapath
  logic [RW-1:0]        row;
  cnt_t                 cnt;
  cnt_t                 cnt_inc;
  logic [SW-1:0]        raw;
  logic [SW-1:0]        flt_val;
  logic [SW-1:0]        rd_src_val;
  off_t                 rd_off;
  logic signed [CW-1:0] diff;
  value_t               sat;
  flt_ctrl_t            flt_ctrl;
  flt_idx_t             flt_idx;
  logic                 o_valid;
  value_t               o_value;
  logic                 o_err;

  always_comb begin
    row     = fwd ? fwd_row : (rd_ent_valid ? rd_q : '0);
    cnt     = row[SW +: CNT_BITS];
    raw     = row[SW-1:0];
    cnt_inc = cnt + 8'd1;
    if (cnt_inc == '0) begin
      cnt_inc = 8'd1;  // wraps past zero
    end
    wr_row  = {cnt_inc, s1_x};
    flt_idx = flt_idx_t'(s1_sel - SEL_FLT_FIRST);
  end

  mrec_filter_bank #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_flt (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (flt_ctrl),
    .x      (s1_x),
    .raw0   (raw),
    .rd_idx (flt_idx),
    .rd_val (flt_val)
  );

  always_comb begin
    rd_src_val = (s1_sel >= SEL_FLT_FIRST) ? flt_val : raw;
    rd_off     = (s1_sel == SEL_AUX) ? aux_offset : main_offset;
    if (s1_sel == SEL_VDD) begin
      diff = $signed(CW'(raw) << 1);
    end else begin
      diff = $signed(CW'(rd_src_val)) - $signed(CW'(rd_off));
    end
    priority if (diff > SAT_HI) begin
      sat = VALUE_MAX;
    end else if (diff < SAT_LO) begin
      sat = VALUE_MIN;
    end else begin
      sat = value_t'(diff);
    end
  end

  always_comb begin
    wr_en        = 1'b0;
    flt_ctrl.upd = 1'b0;
    flt_ctrl.ld  = 1'b0;
    flt_ctrl.idx = flt_idx;
    o_valid      = 1'b0;
    o_value      = '0;
    o_err        = 1'b0;
    unique case (s1_op)
      OP_SAMPLE: begin
        wr_en        = s1_fire;
        flt_ctrl.upd = s1_fire && (s1_src == SRC_MAIN);
      end
      OP_READ: begin
        if (s1_sel == SEL_INVALID) begin
          o_err = 1'b1;
        end else if (cnt != '0) begin
          o_valid = 1'b1;
          o_value = sat;
        end
      end
      OP_RESET: begin
        if (s1_sel >= SEL_FLT_FIRST && s1_sel <= SEL_FLT_LAST) begin
          flt_ctrl.ld = s1_fire;
        end else begin
          o_err = 1'b1;
        end
      end
      default: o_err = 1'b1;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res.value_valid      <= o_valid;
      res.value            <= o_value;
      res.next_source      <= s1_src_after;
      res.reference_select <= (s1_src_after == SRC_VDD);
      res.error            <= o_err;
    end
  end

  a_src_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == OP_SAMPLE) |=> (cur_src != $past(cur_src)))
    else $error("source did not advance after a sample");

  a_valid_err_excl: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.value_valid && res.error))
    else $error("result flagged both valid and error");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res.valid && !res.ready) |-> !cmd.ready)
    else $error("request taken while pipe is stalled");

  a_fwd_owned: assert property (@(posedge clk) disable iff (rst)
    fwd |-> s1_valid)
    else $error("forwarding flag without a request in stage 1");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (ent_valid == '0 && !s1_valid))
    else $error("memory valid bits not cleared by reset");

endmodule

`default_nettype wire

/* sv/mrec_filter_bank.sv */
// Four shift-based leaky integrators (shifts 2, 4, 6, 9) on main pressure.
// Depends on mrec_pkg.
`default_nettype none

module mrec_filter_bank #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mrec_pkg::flt_ctrl_t    ctrl,
  input  wire logic [SAMPLE_BITS-1:0] x,
  input  wire logic [SAMPLE_BITS-1:0] raw0,
  input  wire mrec_pkg::flt_idx_t     rd_idx,
  output logic [SAMPLE_BITS-1:0]      rd_val
);
  import mrec_pkg::*;

  localparam int AW = SAMPLE_BITS + 9;
  localparam int PW = AW + 10;

  logic [SAMPLE_BITS-1:0] lane_out [NUM_FLT];

  for (genvar i = 0; i < NUM_FLT; i++) begin : g_lane
    localparam int S = int'(flt_shift(flt_idx_t'(i)));

    logic [AW-1:0] acc;
    logic [PW-1:0] wide;
    logic [AW-1:0] acc_next;

    // ((2^s - 1) * acc + (x << s)) >> s
    always_comb begin
      wide     = (PW'(acc) << S) - PW'(acc) + (PW'(x) << S);
      acc_next = AW'(wide >> S);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        acc <= '0;
      end else if (ctrl.upd) begin
        acc <= acc_next;
      end else if (ctrl.ld && ctrl.idx == flt_idx_t'(i)) begin
        acc <= AW'(raw0) << S;
      end
    end

    assign lane_out[i] = acc[S +: SAMPLE_BITS];
  end

  assign rd_val = lane_out[rd_idx];

endmodule

`default_nettype wire
